// ----- rtl/assert_macros.svh -----
// Assertion macros for the quarter ellipse point generator.
// No dependencies; the including module must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QEPG_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("qepg assertion failed");
`define QEPG_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qepg assertion failed");
`define QEPG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qepg assertion failed");
`else
`define QEPG_ASSERT(label, prop)
`define QEPG_ASSERT_IMPL(label, ante, cons)
`define QEPG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/qepg_pkg.sv -----
// Shared types and constants of the quarter ellipse point generator.
// No dependencies.
package qepg_pkg;

	// field and internal widths
	localparam int AXIS_W  = 15;
	localparam int COORD_W = 16;
	localparam int SQ_W    = 32;
	localparam int ABSQ_W  = 30;
	localparam int MUL_W   = 32;
	localparam int R_W     = 60;
	localparam int PROD_W  = 62;
	localparam int ERR_W   = 63;

	// largest accepted semi-axis
	localparam logic [COORD_W-1:0] AXIS_MAX = 16'h7FFF;

	// opcodes
	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_POINT  = 2'd0;
	localparam logic [1:0] STAT_REJECT = 2'd1;
	localparam logic [1:0] STAT_NOARC  = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WALK = 2'd1,
		PH_BURN = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		MUL_NONE = 4'd0,
		MUL_AA   = 4'd1,
		MUL_BB   = 4'd2,
		MUL_XX   = 4'd3,
		MUL_R    = 4'd4,
		MUL_BX   = 4'd5,
		MUL_AY   = 4'd6,
		MUL_BN   = 4'd7,
		MUL_AN   = 4'd8
	} mul_sel_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_X    = 2'd1,
		ERR_Y    = 2'd2,
		ERR_B    = 2'd3
	} err_sel_t;

	typedef enum logic [1:0] {
		EM_NONE   = 2'd0,
		EM_POINT  = 2'd1,
		EM_REJECT = 2'd2,
		EM_NOARC  = 2'd3
	} emit_t;

	typedef enum logic [3:0] {
		CS_IDLE       = 4'd0,
		CS_SQ_A       = 4'd1,
		CS_SQ_B       = 4'd2,
		CS_SQ_X       = 4'd3,
		CS_MUL_R      = 4'd4,
		CS_MUL_BX     = 4'd5,
		CS_MUL_AY     = 4'd6,
		CS_MUL_AN     = 4'd7,
		CS_ERR_Y      = 4'd8,
		CS_ERR_B      = 4'd9,
		CS_DECIDE     = 4'd10,
		CS_EMIT_PT    = 4'd11,
		CS_EMIT_REJ   = 4'd12,
		CS_EMIT_NOARC = 4'd13
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic     load_axes;
		logic     burn;
		mul_sel_t mul;
		err_sel_t err;
		logic     decide;
		emit_t    emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		phase_t phase;
		logic   too_large;
		logic   slot_free;
	} dp_stat_t;

endpackage

// ----- rtl/quarter_ellipse_point_generator.sv -----
// Quarter ellipse point generator: qepg_ctrl sequences qepg_dp; uses qepg_pkg.
// Items are handled one at a time: a new start or advance is accepted only after the
// previous result (point, reject or no arc) has been written to the output register.
// Work runs on the one shared 32x32 multiplier (six products on start, two per walk point)
// and the one shared error unit (three errors per walk point). Output register decouples.
// arst_n clears the sequencer, walk phase and output valid; no arc is active after reset.
`include "assert_macros.svh"

module quarter_ellipse_point_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic               opcode,
	input  logic [15:0]        semi_axis_a,
	input  logic [15:0]        semi_axis_b,
	output logic               pt_valid,
	input  logic               pt_ready,
	output logic signed [15:0] point_x,
	output logic [14:0]        point_y,
	output logic               point_last,
	output logic [1:0]         status
);
	import qepg_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	logic     coords_zero;

	// sequencer
	qepg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.opcode    (opcode),
		.cmd_ready (cmd_ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// arithmetic and output register
	qepg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.semi_axis_a (semi_axis_a),
		.semi_axis_b (semi_axis_b),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.pt_valid    (pt_valid),
		.pt_ready    (pt_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_last  (point_last),
		.status      (status)
	);

	assign coords_zero = (point_x == '0) && (point_y == '0) && !point_last;

	// an accepted item drops cmd_ready, so no two items are taken back to back
	`QEPG_ASSERT_NEXT(a_accept_busy, cmd_valid && cmd_ready, !cmd_ready)
	// status results carry no coordinates
	`QEPG_ASSERT_IMPL(a_status_zero, pt_valid && status != STAT_POINT, coords_zero)
	// a last point leaves no active arc behind it
	`QEPG_ASSERT_IMPL(a_last_idle, pt_valid && point_last, dp_stat.phase == PH_IDLE)

endmodule

// ----- rtl/qepg_ctrl.sv -----
// Sequencer of the quarter ellipse point generator.
// Depends on qepg_pkg; drives the command struct of qepg_dp.
module qepg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               opcode,
	output logic               cmd_ready,
	input  qepg_pkg::dp_stat_t stat,
	output qepg_pkg::dp_cmd_t  cmd
);
	import qepg_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        accept;

	assign cmd_ready = (state_q == CS_IDLE);
	assign accept    = cmd_valid && cmd_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (accept) begin
					if (opcode == OP_START) begin
						state_d = stat.too_large ? CS_EMIT_REJ : CS_SQ_A;
					end else begin
						unique case (stat.phase)
							PH_WALK: state_d = CS_MUL_AN;
							PH_BURN: state_d = CS_EMIT_PT;
							default: state_d = CS_EMIT_NOARC;
						endcase
					end
				end
			end
			CS_SQ_A:   state_d = CS_SQ_B;
			CS_SQ_B:   state_d = CS_SQ_X;
			CS_SQ_X:   state_d = CS_MUL_R;
			CS_MUL_R:  state_d = CS_MUL_BX;
			CS_MUL_BX: state_d = CS_MUL_AY;
			CS_MUL_AY: state_d = CS_EMIT_PT;
			CS_MUL_AN: state_d = CS_ERR_Y;
			CS_ERR_Y:  state_d = CS_ERR_B;
			CS_ERR_B:  state_d = CS_DECIDE;
			CS_DECIDE: state_d = CS_EMIT_PT;
			CS_EMIT_PT, CS_EMIT_REJ, CS_EMIT_NOARC: begin
				if (stat.slot_free) begin
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			CS_IDLE: begin
				if (accept) begin
					if (opcode == OP_START) begin
						cmd.load_axes = !stat.too_large;
					end else if (stat.phase == PH_WALK) begin
						cmd.mul = MUL_BN;
					end else if (stat.phase == PH_BURN) begin
						cmd.burn = 1'b1;
					end
				end
			end
			CS_SQ_A:   cmd.mul = MUL_AA;
			CS_SQ_B:   cmd.mul = MUL_BB;
			CS_SQ_X:   cmd.mul = MUL_XX;
			CS_MUL_R:  cmd.mul = MUL_R;
			CS_MUL_BX: cmd.mul = MUL_BX;
			CS_MUL_AY: cmd.mul = MUL_AY;
			CS_MUL_AN: begin
				cmd.mul = MUL_AN;
				cmd.err = ERR_X;
			end
			CS_ERR_Y:  cmd.err = ERR_Y;
			CS_ERR_B:  cmd.err = ERR_B;
			CS_DECIDE: cmd.decide = 1'b1;
			CS_EMIT_PT: begin
				if (stat.slot_free) begin
					cmd.emit = EM_POINT;
				end
			end
			CS_EMIT_REJ: begin
				if (stat.slot_free) begin
					cmd.emit = EM_REJECT;
				end
			end
			CS_EMIT_NOARC: begin
				if (stat.slot_free) begin
					cmd.emit = EM_NOARC;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ----- rtl/qepg_dp.sv -----
// Datapath of the quarter ellipse point generator: arc state, shared
// multiplier, shared error unit and output register. Depends on qepg_pkg.
module qepg_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [qepg_pkg::COORD_W-1:0]         semi_axis_a,
	input  logic [qepg_pkg::COORD_W-1:0]         semi_axis_b,
	input  qepg_pkg::dp_cmd_t                    cmd,
	output qepg_pkg::dp_stat_t                   stat,
	output logic                                 pt_valid,
	input  logic                                 pt_ready,
	output logic signed [qepg_pkg::COORD_W-1:0]  point_x,
	output logic [qepg_pkg::AXIS_W-1:0]          point_y,
	output logic                                 point_last,
	output logic [1:0]                           status
);
	import qepg_pkg::*;

	// arc state
	logic [AXIS_W-1:0]  a_q;
	logic [AXIS_W-1:0]  b_q;       // also the y limit of the walk
	logic [COORD_W-1:0] cur_x_q;
	logic [AXIS_W-1:0]  cur_y_q;
	logic [ABSQ_W-1:0]  a_sq_q, b_sq_q;
	logic [SQ_W-1:0]    x_sq_q, y_sq_q;
	logic [SQ_W-1:0]    nx2_q, ny2_q;
	logic [R_W-1:0]     r_q;
	logic [PROD_W-1:0]  p_bx_q, p_ay_q, p_bn_q, p_an_q;
	logic [ERR_W-1:0]   e_x_q, e_y_q, e_b_q;
	phase_t             phase_q;

	// output register
	logic                      pt_valid_q;
	logic [COORD_W-1:0]        point_x_q;
	logic [AXIS_W-1:0]         point_y_q;
	logic                      point_last_q;
	logic [1:0]                status_q;

	logic [MUL_W-1:0]   x_ext;
	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [2*MUL_W-1:0] prod;
	logic [PROD_W-1:0]  err_p0, err_p1;
	logic [ERR_W-1:0]   err_sum, err_r, err_val;
	logic [SQ_W-1:0]    nx2_d, ny2_d;
	logic               move_x, move_y;
	logic               y_more, x_more;
	phase_t             fol_phase;
	logic               too_large;

	assign x_ext     = {{(MUL_W-COORD_W){cur_x_q[COORD_W-1]}}, cur_x_q};
	assign too_large = (semi_axis_a > AXIS_MAX) || (semi_axis_b > AXIS_MAX);

	// shared 32x32 multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul)
			MUL_AA: begin
				mul_a = {{(MUL_W-AXIS_W){1'b0}}, a_q};
				mul_b = {{(MUL_W-AXIS_W){1'b0}}, a_q};
			end
			MUL_BB: begin
				mul_a = {{(MUL_W-AXIS_W){1'b0}}, b_q};
				mul_b = {{(MUL_W-AXIS_W){1'b0}}, b_q};
			end
			MUL_XX: begin
				mul_a = x_ext;
				mul_b = x_ext;
			end
			MUL_R: begin
				mul_a = {{(MUL_W-ABSQ_W){1'b0}}, a_sq_q};
				mul_b = {{(MUL_W-ABSQ_W){1'b0}}, b_sq_q};
			end
			MUL_BX: begin
				mul_a = {{(MUL_W-ABSQ_W){1'b0}}, b_sq_q};
				mul_b = x_sq_q;
			end
			MUL_AY: begin
				mul_a = {{(MUL_W-ABSQ_W){1'b0}}, a_sq_q};
				mul_b = y_sq_q;
			end
			MUL_BN: begin
				mul_a = {{(MUL_W-ABSQ_W){1'b0}}, b_sq_q};
				mul_b = nx2_q;
			end
			MUL_AN: begin
				mul_a = {{(MUL_W-ABSQ_W){1'b0}}, a_sq_q};
				mul_b = ny2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};

	// shared error unit: |p0 + p1 - A^2*B^2|
	always_comb begin
		err_p0 = '0;
		err_p1 = '0;
		unique case (cmd.err)
			ERR_X: begin
				err_p0 = p_bn_q;
				err_p1 = p_ay_q;
			end
			ERR_Y: begin
				err_p0 = p_bx_q;
				err_p1 = p_an_q;
			end
			ERR_B: begin
				err_p0 = p_bn_q;
				err_p1 = p_an_q;
			end
			default: begin
				err_p0 = '0;
				err_p1 = '0;
			end
		endcase
	end

	assign err_sum = {1'b0, err_p0} + {1'b0, err_p1};
	assign err_r   = {{(ERR_W-R_W){1'b0}}, r_q};
	assign err_val = (err_sum >= err_r) ? (err_sum - err_r) : (err_r - err_sum);

	// move choice: x first, then y, then both
	always_comb begin
		priority if ((e_x_q <= e_y_q) && (e_x_q <= e_b_q)) begin
			move_x = 1'b1;
			move_y = 1'b0;
		end else if (e_y_q <= e_b_q) begin
			move_x = 1'b0;
			move_y = 1'b1;
		end else begin
			move_x = 1'b1;
			move_y = 1'b1;
		end
	end

	// squares after one step, prepared when a point goes out
	assign nx2_d = x_sq_q - {x_ext[MUL_W-3:0], 2'b00} + 32'd4;
	assign ny2_d = y_sq_q + {{(SQ_W-AXIS_W-2){1'b0}}, cur_y_q, 2'b00} + 32'd4;

	// phase after the point now held
	assign y_more = ({1'b0, cur_y_q} + 16'd1) < {1'b0, b_q};
	assign x_more = $signed(cur_x_q) > 16'sd1;
	always_comb begin
		priority if (y_more) begin
			fol_phase = PH_WALK;
		end else if (x_more) begin
			fol_phase = PH_BURN;
		end else begin
			fol_phase = PH_IDLE;
		end
	end

	// arc payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_axes) begin
			a_q     <= semi_axis_a[AXIS_W-1:0];
			b_q     <= semi_axis_b[AXIS_W-1:0];
			cur_x_q <= semi_axis_a - 16'd1;
			cur_y_q <= {{(AXIS_W-1){1'b0}}, ~semi_axis_b[0]};
			y_sq_q  <= {{(SQ_W-1){1'b0}}, ~semi_axis_b[0]};
		end
		unique case (cmd.mul)
			MUL_AA:  a_sq_q <= prod[ABSQ_W-1:0];
			MUL_BB:  b_sq_q <= prod[ABSQ_W-1:0];
			MUL_XX:  x_sq_q <= prod[SQ_W-1:0];
			MUL_R:   r_q    <= prod[R_W-1:0];
			MUL_BX:  p_bx_q <= prod[PROD_W-1:0];
			MUL_AY:  p_ay_q <= prod[PROD_W-1:0];
			MUL_BN:  p_bn_q <= prod[PROD_W-1:0];
			MUL_AN:  p_an_q <= prod[PROD_W-1:0];
			default: ;
		endcase
		unique case (cmd.err)
			ERR_X:   e_x_q <= err_val;
			ERR_Y:   e_y_q <= err_val;
			ERR_B:   e_b_q <= err_val;
			default: ;
		endcase
		if (cmd.burn) begin
			cur_x_q <= cur_x_q - 16'd2;
			x_sq_q  <= nx2_q;
		end
		if (cmd.decide) begin
			if (move_x) begin
				cur_x_q <= cur_x_q - 16'd2;
				x_sq_q  <= nx2_q;
				p_bx_q  <= p_bn_q;
			end
			if (move_y) begin
				cur_y_q <= cur_y_q + 15'd2;
				y_sq_q  <= ny2_q;
				p_ay_q  <= p_an_q;
			end
		end
		if (cmd.emit == EM_POINT) begin
			nx2_q <= nx2_d;
			ny2_q <= ny2_d;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		unique case (cmd.emit)
			EM_POINT: begin
				point_x_q    <= cur_x_q;
				point_y_q    <= cur_y_q;
				point_last_q <= (fol_phase == PH_IDLE);
				status_q     <= STAT_POINT;
			end
			EM_REJECT: begin
				point_x_q    <= '0;
				point_y_q    <= '0;
				point_last_q <= 1'b0;
				status_q     <= STAT_REJECT;
			end
			EM_NOARC: begin
				point_x_q    <= '0;
				point_y_q    <= '0;
				point_last_q <= 1'b0;
				status_q     <= STAT_NOARC;
			end
			default: ;
		endcase
	end

	// walk phase and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pt_valid_q <= 1'b0;
		end else begin
			if (cmd.emit == EM_POINT) begin
				phase_q <= fol_phase;
			end else if (cmd.emit == EM_REJECT) begin
				phase_q <= PH_IDLE;
			end
			if (cmd.emit != EM_NONE) begin
				pt_valid_q <= 1'b1;
			end else if (pt_ready) begin
				pt_valid_q <= 1'b0;
			end
		end
	end

	assign stat.phase     = phase_q;
	assign stat.too_large = too_large;
	assign stat.slot_free = !pt_valid_q || pt_ready;

	assign pt_valid   = pt_valid_q;
	assign point_x    = point_x_q;
	assign point_y    = point_y_q;
	assign point_last = point_last_q;
	assign status     = status_q;

endmodule

// ----- test/tb.sv -----
// Self-checking bench for quarter_ellipse_point_generator: a directed table, then
// random start/advance sequences, checked against typed points or an arc walker.
// Depends on qepg_pkg and the generator RTL only.
module tb;
	import qepg_pkg::*;

	// one emitted point or status
	typedef struct packed {
		logic [15:0] x;
		logic [14:0] y;
		logic        last;
		logic [1:0]  st;
	} point_t;

	// one row of the directed table; chk marks a typed-in expected point
	typedef struct packed {
		logic        op;
		logic [15:0] a;
		logic [15:0] b;
		logic        chk;
		point_t      pt;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_ready;
	logic               opcode;
	logic [15:0]        semi_axis_a;
	logic [15:0]        semi_axis_b;
	logic               pt_valid;
	logic               pt_ready;
	logic signed [15:0] point_x;
	logic [14:0]        point_y;
	logic               point_last;
	logic [1:0]         status;

	// arc walker state
	logic [15:0] cur_x;
	logic [15:0] cur_y;
	logic [31:0] x_sq;
	logic [31:0] y_sq;
	logic [31:0] a_sq;
	logic [31:0] b_sq;
	logic [15:0] y_lim;
	phase_t      walk_phase;

	point_t    expected_points[$];
	stim_row_t directed_rows[$];
	int        mismatches   = 0;
	int        items_sent   = 0;
	int        results_seen = 0;
	int        quiet_cycles = 0;
	logic      calm         = 1'b0;

	quarter_ellipse_point_generator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.opcode     (opcode),
		.semi_axis_a(semi_axis_a),
		.semi_axis_b(semi_axis_b),
		.pt_valid   (pt_valid),
		.pt_ready   (pt_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_last (point_last),
		.status     (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// |B^2*xx + A^2*yy - A^2*B^2|, exact in 64 bits
	function automatic logic [63:0] ellipse_error(input logic [31:0] xx, input logic [31:0] yy);
		logic [63:0] aw, bw, xw, yw, s, r;
		aw = {32'b0, a_sq};
		bw = {32'b0, b_sq};
		xw = {32'b0, xx};
		yw = {32'b0, yy};
		s = bw * xw + aw * yw;
		r = aw * bw;
		return (s >= r) ? s - r : r - s;
	endfunction

	// phase after the current point; also builds the point itself
	function automatic point_t emit_arc_point();
		point_t p;
		if ({16'b0, cur_y} + 32'd1 < {16'b0, y_lim})
			walk_phase = PH_WALK;
		else if ($signed(cur_x) > 1)
			walk_phase = PH_BURN;
		else
			walk_phase = PH_IDLE;
		p.x    = cur_x;
		p.y    = cur_y[14:0];
		p.last = (walk_phase == PH_IDLE);
		p.st   = STAT_POINT;
		return p;
	endfunction

	// advance the arc walker by one accepted item
	function automatic point_t next_arc_point(input logic op, input logic [15:0] a,
			input logic [15:0] b);
		point_t      p;
		logic [31:0] xs, nx2, ny2;
		logic [63:0] ex, ey, eb;
		p = '0;
		xs = {{16{cur_x[15]}}, cur_x};
		if (op == OP_START) begin
			if (a > AXIS_MAX || b > AXIS_MAX) begin
				walk_phase = PH_IDLE;
				p.st = STAT_REJECT;
				return p;
			end
			a_sq  = {16'b0, a} * {16'b0, a};
			b_sq  = {16'b0, b} * {16'b0, b};
			y_lim = b;
			cur_x = a - 16'd1;
			cur_y = b[0] ? 16'd0 : 16'd1;
			xs    = {{16{cur_x[15]}}, cur_x};
			x_sq  = xs * xs;
			y_sq  = {16'b0, cur_y} * {16'b0, cur_y};
			return emit_arc_point();
		end
		case (walk_phase)
			PH_WALK: begin
				nx2 = x_sq - 32'd4 * xs + 32'd4;
				ny2 = y_sq + 32'd4 * {16'b0, cur_y} + 32'd4;
				ex = ellipse_error(nx2, y_sq);
				ey = ellipse_error(x_sq, ny2);
				eb = ellipse_error(nx2, ny2);
				// ties favor the x move, then the y move
				if (ex <= ey && ex <= eb) begin
					cur_x = cur_x - 16'd2;
					x_sq  = nx2;
				end else if (ey <= eb) begin
					cur_y = cur_y + 16'd2;
					y_sq  = ny2;
				end else begin
					cur_x = cur_x - 16'd2;
					x_sq  = nx2;
					cur_y = cur_y + 16'd2;
					y_sq  = ny2;
				end
				return emit_arc_point();
			end
			PH_BURN: begin
				x_sq  = x_sq - 32'd4 * xs + 32'd4;
				cur_x = cur_x - 16'd2;
				return emit_arc_point();
			end
			default: begin
				p.st = STAT_NOARC;
				return p;
			end
		endcase
	endfunction

	function automatic void add_row(input logic op, input logic [15:0] a, input logic [15:0] b,
			input logic chk, input logic [15:0] x, input logic [14:0] y, input logic last,
			input logic [1:0] st);
		stim_row_t r;
		r.op = op;
		r.a = a;
		r.b = b;
		r.chk = chk;
		r.pt.x = x;
		r.pt.y = y;
		r.pt.last = last;
		r.pt.st = st;
		directed_rows.push_back(r);
	endfunction

	// offer one item and hold it until accepted
	task automatic send_item(input logic op, input logic [15:0] a, input logic [15:0] b,
			input logic chk, input point_t typed_pt);
		point_t p;
		while (!calm && $urandom_range(99) < 19) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd_valid   = 1'b1;
		opcode      = op;
		semi_axis_a = a;
		semi_axis_b = b;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		p = next_arc_point(op, a, b);
		expected_points.push_back(chk ? typed_pt : p);
		items_sent++;
		calm = (items_sent >= 900 && items_sent < 1150);
		@(negedge clk);
	endtask

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch at result %0d: %s got %0d expected %0d", results_seen, field, got,
			want);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin
		point_t want;
		if (arst_n && pt_valid && pt_ready) begin
			if (expected_points.size() == 0) begin
				report_mismatch("unexpected result, status", status, -1);
			end else begin
				want = expected_points.pop_front();
				if (point_x !== want.x)
					report_mismatch("point_x", point_x, $signed(want.x));
				if (point_y !== want.y)
					report_mismatch("point_y", point_y, want.y);
				if (point_last !== want.last)
					report_mismatch("point_last", point_last, want.last);
				if (status !== want.st)
					report_mismatch("status", status, want.st);
			end
			results_seen++;
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (pt_valid && pt_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 5000) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("tb failed");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off, none during the calm stretch
	initial begin
		int   hold_left;
		logic hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		pt_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 400) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				pt_ready = 1'b0;
				hold_left--;
			end else begin
				pt_ready = calm || ($urandom_range(99) >= 19);
			end
		end
	end

	// reset, directed table, random sequences, drain
	initial begin
		int          pick, cap, n;
		logic [15:0] a, b;
		arst_n      = 1'b0;
		cmd_valid   = 1'b0;
		opcode      = OP_START;
		semi_axis_a = '0;
		semi_axis_b = '0;
		cur_x       = '0;
		cur_y       = '0;
		x_sq        = '0;
		y_sq        = '0;
		a_sq        = '0;
		b_sq        = '0;
		y_lim       = '0;
		walk_phase  = PH_IDLE;

		// advance after reset, rejects, degenerate and tail-only arcs
		add_row(OP_ADVANCE, 16'h0000, 16'h0000, 1'b1, 16'h0000, 15'd0, 1'b0, STAT_NOARC);
		add_row(OP_START,   16'h8000, 16'h0005, 1'b1, 16'h0000, 15'd0, 1'b0, STAT_REJECT);
		add_row(OP_START,   16'h0005, 16'hFFFF, 1'b1, 16'h0000, 15'd0, 1'b0, STAT_REJECT);
		add_row(OP_START,   16'h0000, 16'h0000, 1'b1, 16'hFFFF, 15'd1, 1'b1, STAT_POINT);
		add_row(OP_ADVANCE, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 15'd0, 1'b0, STAT_NOARC);
		add_row(OP_START,   16'h0001, 16'h0001, 1'b1, 16'h0000, 15'd0, 1'b1, STAT_POINT);
		add_row(OP_START,   16'h0005, 16'h0000, 1'b1, 16'h0004, 15'd1, 1'b0, STAT_POINT);
		add_row(OP_ADVANCE, 16'h0000, 16'h0000, 1'b1, 16'h0002, 15'd1, 1'b0, STAT_POINT);
		add_row(OP_ADVANCE, 16'h0000, 16'h0000, 1'b1, 16'h0000, 15'd1, 1'b1, STAT_POINT);
		add_row(OP_ADVANCE, 16'h0000, 16'h0000, 1'b1, 16'h0000, 15'd0, 1'b0, STAT_NOARC);
		// largest axes, then a reject that drops the active arc
		add_row(OP_START,   16'h7FFF, 16'h7FFF, 1'b0, '0, '0, 1'b0, STAT_POINT);
		repeat (4)
			add_row(OP_ADVANCE, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0, STAT_POINT);
		add_row(OP_START,   16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 15'd0, 1'b0, STAT_REJECT);
		add_row(OP_ADVANCE, 16'h0000, 16'h0000, 1'b1, 16'h0000, 15'd0, 1'b0, STAT_NOARC);
		// small full arc
		add_row(OP_START,   16'h0002, 16'h0003, 1'b0, '0, '0, 1'b0, STAT_POINT);
		repeat (4)
			add_row(OP_ADVANCE, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0, STAT_POINT);
		// flat and zero-width extremes
		add_row(OP_START,   16'h7FFF, 16'h0000, 1'b1, 16'h7FFE, 15'd1, 1'b0, STAT_POINT);
		add_row(OP_START,   16'h0000, 16'h7FFF, 1'b0, '0, '0, 1'b0, STAT_POINT);
		add_row(OP_ADVANCE, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0, STAT_POINT);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
				directed_rows[i].chk, directed_rows[i].pt);

		// mostly whole or cut-short arcs, some noise
		while (items_sent < 1975) begin
			if ($urandom_range(99) < 85) begin
				pick = $urandom_range(9);
				if (pick < 7) begin
					a = 16'($urandom_range(40));
					b = 16'($urandom_range(40));
				end else if (pick < 9) begin
					a = 16'($urandom_range(32767));
					b = 16'($urandom_range(32767));
				end else if ($urandom_range(1)) begin
					a = 16'($urandom_range(65535));
					b = 16'($urandom_range(40));
				end else begin
					a = 16'($urandom_range(40));
					b = 16'($urandom_range(65535));
				end
				send_item(OP_START, a, b, 1'b0, '0);
				cap = ($urandom_range(4) == 0) ? $urandom_range(10) : 300;
				n = 0;
				while (walk_phase != PH_IDLE && n < cap) begin
					send_item(OP_ADVANCE, 16'($urandom_range(65535)),
						16'($urandom_range(65535)), 1'b0, '0);
					n++;
				end
				if ($urandom_range(3) == 0)
					send_item(OP_ADVANCE, 16'($urandom_range(65535)),
						16'($urandom_range(65535)), 1'b0, '0);
			end else begin
				repeat ($urandom_range(1, 4))
					send_item(1'($urandom_range(1)), 16'($urandom_range(65535)),
						16'($urandom_range(65535)), 1'b0, '0);
			end
		end
		cmd_valid = 1'b0;

		// drain, then let the block settle
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/qepg_pkg.sv
rtl/qepg_ctrl.sv
rtl/qepg_dp.sv
rtl/quarter_ellipse_point_generator.sv
test/tb.sv
